@@ design/date_string_validator_top_defines.svh @@
// assertion macros shared by the date string validator rtl
`ifndef DATE_STRING_VALIDATOR_TOP_DEFINES_SVH
`define DATE_STRING_VALIDATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define DSV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dsv assertion failed");
`define DSV_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("dsv forbidden condition seen");
`else
`define DSV_ASSERT(lbl, prop)
`define DSV_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ design/dsv_pkg.sv @@
// types, constants and helper functions of the date string validator
package dsv_pkg;

  localparam logic [7:0] CHAR_HYPHEN = 8'h2d;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [2:0] CNT_MAX       = 3'd7;
  localparam logic [2:0] YEAR_MIN_DIG  = 3'd4;
  localparam logic [2:0] FIELD_MAX_DIG = 3'd2;
  localparam logic [6:0] MONTH_MAX     = 7'd12;
  localparam logic [6:0] MONTH_FEB     = 7'd2;
  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

  typedef enum logic [3:0] {
    PH_YEAR  = 4'b0001,
    PH_MONTH = 4'b0010,
    PH_DAY   = 4'b0100,
    PH_TAIL  = 4'b1000
  } phase_e;

  // one character beat as seen by the update logic
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } beat_t;

  // days in a month, month already known to be in 1..12
  function automatic logic [4:0] month_days(input logic [6:0] month);
    logic [4:0] days;
    case (month)
      7'd2:    days = 5'd28;
      7'd4:    days = 5'd30;
      7'd6:    days = 5'd30;
      7'd9:    days = 5'd30;
      7'd11:   days = 5'd30;
      default: days = 5'd31;
    endcase
    return days;
  endfunction

  // reduce a value below 4000 modulo 400 by parallel compares
  function automatic logic [8:0] mod400(input logic [11:0] x);
    logic [11:0] rem;
    rem = x;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 12'(k * 400)) begin
        rem = x - 12'(k * 400);
      end
    end
    return rem[8:0];
  endfunction

endpackage

@@ design/dsv_core.sv @@
// per-character state update and date check of the date string validator
`include "date_string_validator_top_defines.svh"

module dsv_core #(
  parameter int YEAR_BITS = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  dsv_pkg::beat_t beat_i,
  output logic          verdict_o
);
  import dsv_pkg::*;

  localparam int ProdBits = YEAR_BITS + 4;

  phase_e               phase_q, phase_d;
  logic [2:0]           cnt_q, cnt_d;
  logic [YEAR_BITS-1:0] year_q, year_d;
  logic [8:0]           ymod_q, ymod_d;
  logic [6:0]           month_q, month_d;
  logic [6:0]           day_q, day_d;
  logic                 bad_q, bad_d;

  logic                 is_digit;
  logic [3:0]           dig;
  logic [ProdBits-1:0]  year_ext;
  logic [ProdBits-1:0]  year_prod;
  logic [11:0]          ymod_prod;
  logic                 leap;
  logic [4:0]           limit;

  assign is_digit  = (beat_i.ch >= CHAR_ZERO) && (beat_i.ch <= CHAR_NINE);
  assign dig       = beat_i.ch[3:0];
  assign year_ext  = {4'b0000, year_q};
  // times ten as two shifts
  assign year_prod = (year_ext << 3) + (year_ext << 1) + ProdBits'(dig);
  assign ymod_prod = ({3'b000, ymod_q} << 3) + ({3'b000, ymod_q} << 1) + 12'(dig);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    year_d  = year_q;
    ymod_d  = ymod_q;
    month_d = month_q;
    day_d   = day_q;
    bad_d   = bad_q;
    if (phase_q != PH_TAIL) begin
      if (is_digit) begin
        cnt_d = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 3'd1;
        if (phase_q == PH_YEAR) begin
          if (year_prod[ProdBits-1:YEAR_BITS] != 4'b0000) begin
            bad_d = 1'b1;
          end else begin
            year_d = year_prod[YEAR_BITS-1:0];
          end
          ymod_d = mod400(ymod_prod);
        end else if (cnt_d > FIELD_MAX_DIG) begin
          bad_d = 1'b1;
        end else if (phase_q == PH_MONTH) begin
          month_d = 7'((month_q << 3) + (month_q << 1) + 7'(dig));
        end else begin
          day_d = 7'((day_q << 3) + (day_q << 1) + 7'(dig));
        end
      end else if (beat_i.ch == CHAR_HYPHEN) begin
        if (phase_q == PH_YEAR && cnt_q < YEAR_MIN_DIG) begin
          bad_d = 1'b1;
        end
        case (phase_q)
          PH_YEAR:  phase_d = PH_MONTH;
          PH_MONTH: phase_d = PH_DAY;
          default:  phase_d = PH_TAIL;
        endcase
        cnt_d = 3'd0;
      end else begin
        bad_d = 1'b1;
      end
    end
  end

  // gregorian leap rule on the year modulo 400
  assign leap = ((ymod_d[1:0] == 2'b00) && (ymod_d != 9'd100) && (ymod_d != 9'd200)
                 && (ymod_d != 9'd300));
  assign limit = (month_d == MONTH_FEB && leap) ? FEB_LEAP_DAYS : month_days(month_d);

  assign verdict_o = !bad_d && (phase_d == PH_DAY || phase_d == PH_TAIL)
                     && (year_d != '0) && (month_d != 7'd0) && (month_d <= MONTH_MAX)
                     && (day_d != 7'd0) && (day_d <= {2'b00, limit});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_YEAR;
      cnt_q   <= 3'd0;
      year_q  <= '0;
      ymod_q  <= 9'd0;
      month_q <= 7'd0;
      day_q   <= 7'd0;
      bad_q   <= 1'b0;
    end else if (step_i) begin
      if (beat_i.last) begin
        // string done, start over for the next one
        phase_q <= PH_YEAR;
        cnt_q   <= 3'd0;
        year_q  <= '0;
        ymod_q  <= 9'd0;
        month_q <= 7'd0;
        day_q   <= 7'd0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        year_q  <= year_d;
        ymod_q  <= ymod_d;
        month_q <= month_d;
        day_q   <= day_d;
        bad_q   <= bad_d;
      end
    end
  end

  `DSV_ASSERT(a_clear_after_last, step_i && beat_i.last |=> phase_q == PH_YEAR && !bad_q)
  `DSV_ASSERT(a_mod_in_range, ymod_q < 9'd400)
  `DSV_ASSERT_NEVER(a_tail_holds, step_i && phase_q == PH_TAIL && !beat_i.last
                    && phase_d != PH_TAIL)

endmodule

@@ design/date_string_validator_top.sv @@
// Date string validator: takes one character beat per cycle and, on the beat
// marked last, returns one bit telling whether the string is a correct
// year-month-day date (four or more year digits, month 1..12, day within the
// month with Gregorian leap years, optional hyphen and free tail). A character
// is registered on entry and then folded into the running field state, so
// one character is taken every cycle; the verdict is registered when the
// last character moves on. The per-character update of the field
// registers is the loop that sets this one-per-cycle rate. A finished verdict
// waits in the output register while further characters keep flowing in; only
// a second last character stalls behind an untaken verdict.
`include "date_string_validator_top_defines.svh"

module date_string_validator_top #(
  parameter int YEAR_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o
);
  import dsv_pkg::*;

  logic       s1_valid_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       out_valid_q;
  logic       res_q;
  logic       in_fire;
  logic       advance;
  logic       verdict;
  beat_t      beat;

  // a last beat may only move on when the verdict slot is free or draining
  assign advance    = s1_valid_q && !(last_q && out_valid_q && !out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign beat.ch   = ch_q;
  assign beat.last = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  dsv_core #(
    .YEAR_BITS(YEAR_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .beat_i   (beat),
    .verdict_o(verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

  `DSV_ASSERT(a_last_gives_result, advance && last_q |=> out_valid_q)
  `DSV_ASSERT(a_stall_only_on_full, !in_ready_o |-> s1_valid_q && last_q && out_valid_q)
  `DSV_ASSERT_NEVER(a_no_result_from_nothing, !$past(advance && last_q) && $rose(out_valid_q))

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for date_string_validator_top: random and directed date strings
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsv_pkg::*;

  localparam int YEAR_W = 20;
  localparam longint unsigned YEAR_MAX = (64'd1 << YEAR_W) - 1;
  localparam int RANDOM_CHARS = 1050;
  localparam int TAIL_ITEMS = 120;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 200000;
  localparam logic [4:0] DAYS_IN_MONTH [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                                 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] ch_i = 8'h00;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       valid_res_o;

  date_string_validator_top #(
    .YEAR_BITS(YEAR_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .valid_res_o(valid_res_o)
  );

  always #2 clk_i = ~clk_i;

  // string under construction and beats waiting for the driver
  logic [7:0]  text_q [$];
  beat_t       pending_q [$];
  logic        verdict_q [$];
  int unsigned n_live;

  // predictor state for the string being folded
  phase_e      fold_ph;
  logic [2:0]  fold_cnt;
  logic [YEAR_W-1:0] fold_year;
  logic [8:0]  fold_y400;
  logic [6:0]  fold_month;
  logic [6:0]  fold_day;
  logic        fold_bad;

  int          err_cnt = 0;
  int          n_accepted = 0;
  int          cyc = 0;
  int          gap_left = 0;
  int          quiet_items = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm = 1'b0;
  beat_t       offer;
  logic        want;

  function automatic void clear_fold();
    fold_ph    = PH_YEAR;
    fold_cnt   = '0;
    fold_year  = '0;
    fold_y400  = '0;
    fold_month = '0;
    fold_day   = '0;
    fold_bad   = 1'b0;
  endfunction

  function automatic void fold_char(input logic [7:0] c);
    logic [3:0] v;
    longint unsigned nv;
    v = 4'(c - CHAR_ZERO);
    if (fold_ph == PH_TAIL) return;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      if (fold_cnt != CNT_MAX) fold_cnt++;
      if (fold_ph == PH_YEAR) begin
        nv = 64'(fold_year) * 10 + 64'(v);
        if (nv > YEAR_MAX) fold_bad = 1'b1;
        else fold_year = nv[YEAR_W-1:0];
        fold_y400 = 9'((32'(fold_y400) * 10 + 32'(v)) % 400);
      end else if (fold_cnt > FIELD_MAX_DIG) begin
        fold_bad = 1'b1;
      end else if (fold_ph == PH_MONTH) begin
        fold_month = 7'(32'(fold_month) * 10 + 32'(v));
      end else begin
        fold_day = 7'(32'(fold_day) * 10 + 32'(v));
      end
    end else if (c == CHAR_HYPHEN) begin
      if (fold_ph == PH_YEAR && fold_cnt < YEAR_MIN_DIG) fold_bad = 1'b1;
      case (fold_ph)
        PH_YEAR:  fold_ph = PH_MONTH;
        PH_MONTH: fold_ph = PH_DAY;
        default:  fold_ph = PH_TAIL;
      endcase
      fold_cnt = '0;
    end else begin
      fold_bad = 1'b1;
    end
  endfunction

  function automatic logic date_verdict();
    logic leap;
    logic [4:0] lim;
    if (fold_bad || fold_ph == PH_YEAR || fold_ph == PH_MONTH) return 1'b0;
    if (fold_year == 0 || fold_month == 0 || fold_month > MONTH_MAX || fold_day == 0)
      return 1'b0;
    leap = (fold_y400 % 4 == 0 && fold_y400 % 100 != 0) || fold_y400 == 0;
    lim = DAYS_IN_MONTH[fold_month - 7'd1];
    if (fold_month == MONTH_FEB && leap) lim = FEB_LEAP_DAYS;
    return fold_day <= 7'(lim);
  endfunction

  function automatic void put_num(input int unsigned val, input int unsigned ndig);
    logic [7:0] digs [$];
    int unsigned rest;
    rest = val;
    do begin
      digs.push_front(8'(CHAR_ZERO + rest % 10));
      rest = rest / 10;
    end while (rest != 0 || digs.size() < ndig);
    foreach (digs[k]) text_q.push_back(digs[k]);
  endfunction

  function automatic void put_str(input string s);
    for (int k = 0; k < s.len(); k++) text_q.push_back(8'(s[k]));
  endfunction

  // turn the string into beats, last marker on the final one
  function automatic void flush_text(input int unsigned live);
    beat_t b;
    foreach (text_q[k]) begin
      b.ch   = text_q[k];
      b.last = (k == text_q.size() - 1);
      pending_q.push_back(b);
    end
    text_q.delete();
    n_live += live;
  endfunction

  function automatic void gen_date();
    int unsigned yr, mo, dy, ydig, cut, live;
    case ($urandom_range(0, 11))
      0:       yr = 2000;
      1:       yr = 100 * $urandom_range(1, 99);
      2:       yr = 4 * $urandom_range(1, 2499);
      3:       yr = $urandom_range(1048570, 1048580);
      4:       yr = $urandom_range(1048576, 99999999);
      5:       yr = 0;
      default: yr = $urandom_range(1, 9999);
    endcase
    ydig = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 4;
    put_num(yr, ydig);
    text_q.push_back(CHAR_HYPHEN);
    case ($urandom_range(0, 7))
      0:       mo = $urandom_range(0, 120);
      1, 2:    mo = 2;
      default: mo = $urandom_range(1, 12);
    endcase
    // an empty field now and then
    if ($urandom_range(0, 31) != 0) put_num(mo, $urandom_range(1, 2));
    text_q.push_back(CHAR_HYPHEN);
    case ($urandom_range(0, 7))
      0:       dy = $urandom_range(0, 120);
      1, 2:    dy = $urandom_range(28, 31);
      default: dy = $urandom_range(1, 31);
    endcase
    if ($urandom_range(0, 31) != 0) put_num(dy, $urandom_range(1, 2));
    live = text_q.size();
    case ($urandom_range(0, 3))
      0: begin
        text_q.push_back(CHAR_HYPHEN);
        live++;
        repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        text_q.push_back(CHAR_HYPHEN);
        live++;
      end
      default: ;
    endcase
    // broken strings: one corrupted character or an early end
    case ($urandom_range(0, 9))
      0: text_q[$urandom_range(0, live - 1)] = 8'($urandom_range(0, 255));
      1: begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
        if (live > cut) live = cut;
      end
      default: ;
    endcase
    flush_text(live);
  endfunction

  function automatic void gen_noise();
    int unsigned len;
    len = $urandom_range(1, 8);
    repeat (len) begin
      case ($urandom_range(0, 3))
        0:       text_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        1:       text_q.push_back(CHAR_HYPHEN);
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    flush_text(len);
  endfunction

  function automatic void log_fail(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // driver: offer beats from pending_q, fold accepted beats into the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        fold_char(ch_i);
        if (last_i) begin
          verdict_q.push_back(date_verdict());
          clear_fold();
        end
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          offer = pending_q.pop_front();
          in_valid_i <= 1'b1;
          ch_i <= offer.ch;
          last_i <= offer.last;
          if (quiet_items != 0) quiet_items--;
          else if ($urandom_range(0, 63) == 0) quiet_items = $urandom_range(20, 80);
          else if (pending_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      calm <= (pending_q.size() < TAIL_ITEMS);
    end
  end

  // one long hold-off on the result side so the input backs up
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor: compare each verdict beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          log_fail($sformatf("verdict %0b with none predicted", valid_res_o));
        end else begin
          want = verdict_q.pop_front();
          if (valid_res_o !== want)
            log_fail($sformatf("verdict mismatch: expected %0b, got %0b", want, valid_res_o));
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (quiet_cycles != 0) quiet_cycles--;
        else if ($urandom_range(0, 127) == 0) quiet_cycles = $urandom_range(30, 150);
        else if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT_CYCLES) begin
      $display("date_string_validator_top regression: fail");
      $finish;
    end
  end

  initial begin
    clear_fold();
    n_live = 0;
    // directed strings: byte extremes, lone hyphen, zero fields, leap day with tail
    text_q.push_back(8'hff);
    flush_text(1);
    text_q.push_back(8'h00);
    flush_text(1);
    put_str("-");
    flush_text(1);
    put_str("0000-0-0");
    flush_text(8);
    put_str("2000-02-29-");
    text_q.push_back(8'hff);
    flush_text(11);
    n_live = 0;
    while (n_live < RANDOM_CHARS) begin
      if ($urandom_range(0, 4) == 0) gen_noise();
      else gen_date();
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (verdict_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("date_string_validator_top regression: pass");
    end else begin
      $display("date_string_validator_top regression: fail");
    end
    $finish;
  end

endmodule
